@@ hw/rtl/sgm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants of the Sobel gradient magnitude block
// Register indexes, field widths, reset values and the per-request flag group
// that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sgm_pkg;

   // Default dimension limits of the line stores and row counter
   localparam int SGM_MAX_WIDTH  = 2048;
   localparam int SGM_MAX_HEIGHT = 4096;

   // Field and register widths
   localparam int SGM_PIXEL_W      = 8;
   localparam int SGM_WIDTH_REG_W  = 12;
   localparam int SGM_HEIGHT_REG_W = 13;
   localparam int SGM_CSR_DATA_W   = 13;
   localparam int SGM_CSR_ADDR_W   = 1;

   // Register reset values
   localparam int SGM_RESET_WIDTH  = 640;
   localparam int SGM_RESET_HEIGHT = 480;

   // Depth of the queue between front and back end
   localparam int SGM_QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [SGM_CSR_ADDR_W-1:0] SGM_REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [SGM_CSR_ADDR_W-1:0] SGM_REG_IMAGE_HEIGHT = 1'd1;

   // Classification of one request
   typedef struct packed {
      logic emit;       // centre pixel is interior: a result follows
      logic frame_end;  // result belongs to the last interior pixel
   } sgm_flags_type;

endpackage

@@ hw/rtl/sgm_queue.sv @@
// ----------------------------------------------------------------------------
// sgm_queue: small register FIFO between front and back end
// Holds classified requests so that either side can stall on its own.
// ----------------------------------------------------------------------------
module sgm_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sgm_front.sv @@
// ----------------------------------------------------------------------------
// sgm_front: request intake and classification
// Holds the dimension registers and the column and row counters, tags each
// request with its column and with whether it produces a result.
// ----------------------------------------------------------------------------
module sgm_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sgm_pkg::SGM_CSR_ADDR_W-1:0] csr_addr,
   input  logic [sgm_pkg::SGM_CSR_DATA_W-1:0] csr_wdata,
   input  logic                               req_accept,
   input  logic                               frame_start,
   output logic [COL_W-1:0]                   col,
   output sgm_pkg::sgm_flags_type             flags
);
   import sgm_pkg::*;

   // Saturate a dimension to [3, hi]
   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      int unsigned r;
      r = v;
      if (v < 3) begin
         r = 3;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   localparam logic [COL_W-1:0] RESET_W_LAST =
      COL_W'(clamp_dim(SGM_RESET_WIDTH, MAX_WIDTH) - 1);
   localparam logic [ROW_W-1:0] RESET_H_LAST =
      ROW_W'(clamp_dim(SGM_RESET_HEIGHT, MAX_HEIGHT) - 1);

   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] row;
   logic             last_col, last_row;

   // Keep the last column and last row index, saturated on write
   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_we) begin
         unique case (csr_addr)
            SGM_REG_IMAGE_WIDTH: begin
               w_last_in = COL_W'(clamp_dim(32'(csr_wdata[SGM_WIDTH_REG_W-1:0]),
                                            MAX_WIDTH) - 1);
            end
            SGM_REG_IMAGE_HEIGHT: begin
               h_last_in = ROW_W'(clamp_dim(32'(csr_wdata[SGM_HEIGHT_REG_W-1:0]),
                                            MAX_HEIGHT) - 1);
            end
            default: begin
            end
         endcase
      end
   end

   // Classify the position of the incoming pixel
   assign col      = frame_start ? '0 : col_ff;
   assign row      = frame_start ? '0 : row_ff;
   assign last_col = (col >= w_last_ff);
   assign last_row = (row >= h_last_ff);

   assign flags.emit      = (row >= ROW_W'(2)) && (col >= COL_W'(2));
   assign flags.frame_end = last_col && last_row;

   // Step the raster counters, wrapping at row and frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row + ROW_W'(1);
         end else begin
            col_in = col + COL_W'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= RESET_W_LAST;
         h_last_ff <= RESET_H_LAST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

@@ hw/rtl/sgm_back.sv @@
// ----------------------------------------------------------------------------
// sgm_back: line stores, window, gradient and square-root pipeline
// Reads the two stored rows, shifts the 3x3 window, forms gx and gy, squares
// and sums them and takes a pipelined integer square root, one bit a stage.
// ----------------------------------------------------------------------------
module sgm_back #(
   parameter int MAX_WIDTH = 2048,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  logic [sgm_pkg::SGM_PIXEL_W-1:0]  q_pixel,
   input  logic [COL_W-1:0]                 q_col,
   input  sgm_pkg::sgm_flags_type           q_flags,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // [7:0] magnitude
   output logic                             rsp_tlast   // frame_end
);
   import sgm_pkg::*;

   localparam int STAGES = 8;

   logic advance;

   // Line store: upper byte two rows back, lower byte one row back
   logic [15:0]            line_mem [MAX_WIDTH];
   logic [15:0]            rd_ff;
   logic                   fwd_ff, fwd_in;
   logic [15:0]            fwd_data_ff;

   // Window stage
   logic                   b1_valid_ff;
   logic [7:0]             b1_pixel_ff;
   logic [COL_W-1:0]       b1_col_ff;
   sgm_flags_type          b1_flags_ff;
   logic [7:0]             win_ff [6];
   logic [7:0]             top, mid;
   logic [9:0]             sum_left, sum_right, sum_up, sum_down;
   logic signed [10:0]     gx_in, gy_in;

   // Gradient stage
   logic                   g_valid_ff;
   logic                   g_last_ff;
   logic signed [10:0]     gx_ff, gy_ff;
   logic signed [21:0]     sqx_full, sqy_full;

   // Square stage
   logic                   p_valid_ff;
   logic                   p_last_ff;
   logic [19:0]            sqx_ff, sqy_ff;
   logic [20:0]            sq_sum;

   // Square-root stages
   logic                   s_valid_ff [STAGES+1];
   logic                   s_last_ff  [STAGES+1];
   logic                   s_sat_ff   [STAGES+1];
   logic [15:0]            s_val_ff   [STAGES+1];
   logic [7:0]             s_root_ff  [STAGES+1];
   logic [7:0]             s_rem_ff   [STAGES+1];
   logic [15:0]            s_val_in   [STAGES];
   logic [7:0]             s_root_in  [STAGES];
   logic [7:0]             s_rem_in   [STAGES];
   logic [9:0]             rem_sh     [STAGES];
   logic [9:0]             trial      [STAGES];
   logic [9:0]             rem_sub    [STAGES];

   // Output register
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_mag_ff;
   logic                   rsp_last_ff;

   // Move the whole pipeline when the output register can take a result
   assign advance = !rsp_valid_ff || rsp_tready;
   assign q_pop   = advance && q_valid;

   // Read the stored rows for the popped request
   assign fwd_in = b1_valid_ff && (q_col == b1_col_ff);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= line_mem[q_col];
      end
   end

   // Write back one row down: old previous row becomes two rows back
   always_ff @(posedge clock) begin
      if (advance && b1_valid_ff) begin
         line_mem[b1_col_ff] <= {mid, b1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_pixel_ff <= q_pixel;
         b1_col_ff   <= q_col;
         b1_flags_ff <= q_flags;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= {mid, b1_pixel_ff};
      end
   end

   // Take the column just written when it is read in the same cycle
   assign top = fwd_ff ? fwd_data_ff[15:8] : rd_ff[15:8];
   assign mid = fwd_ff ? fwd_data_ff[7:0]  : rd_ff[7:0];

   // Gradients: left minus right column, top minus bottom row
   assign sum_left  = {2'b0, win_ff[3]} + {1'b0, win_ff[4], 1'b0} + {2'b0, win_ff[5]};
   assign sum_right = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, b1_pixel_ff};
   assign sum_up    = {2'b0, win_ff[3]} + {1'b0, win_ff[0], 1'b0} + {2'b0, top};
   assign sum_down  = {2'b0, win_ff[5]} + {1'b0, win_ff[2], 1'b0} + {2'b0, b1_pixel_ff};
   assign gx_in     = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
   assign gy_in     = $signed({1'b0, sum_up}) - $signed({1'b0, sum_down});

   // Shift the window one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance && b1_valid_ff) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= b1_pixel_ff;
      end
   end

   // Gradient registers, only for interior pixels
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         g_valid_ff <= b1_valid_ff && b1_flags_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         g_last_ff <= b1_flags_ff.frame_end;
      end
   end

   // Square both gradients
   assign sqx_full = gx_ff * gx_ff;
   assign sqy_full = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff    <= sqx_full[19:0];
         sqy_ff    <= sqy_full[19:0];
         p_last_ff <= g_last_ff;
      end
   end

   // Sum; anything at or above 2^16 saturates the root to 255
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // One root bit per stage from two radicand bits
   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         rem_sh[s]   = {s_rem_ff[s], s_val_ff[s][15:14]};
         trial[s]    = {1'b0, s_root_ff[s][6:0], 2'b01};
         rem_sub[s]  = rem_sh[s] - trial[s];
         s_val_in[s] = {s_val_ff[s][13:0], 2'b00};
         if (rem_sh[s] >= trial[s]) begin
            s_rem_in[s]  = rem_sub[s][7:0];
            s_root_in[s] = {s_root_ff[s][6:0], 1'b1};
         end else begin
            s_rem_in[s]  = rem_sh[s][7:0];
            s_root_in[s] = {s_root_ff[s][6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STAGES; s++) begin
            s_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         s_valid_ff[0] <= p_valid_ff;
         for (int s = 0; s < STAGES; s++) begin
            s_valid_ff[s+1] <= s_valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_last_ff[0] <= p_last_ff;
         s_sat_ff[0]  <= (sq_sum[20:16] != '0);
         s_val_ff[0]  <= sq_sum[15:0];
         s_root_ff[0] <= '0;
         s_rem_ff[0]  <= '0;
         for (int s = 0; s < STAGES; s++) begin
            s_last_ff[s+1] <= s_last_ff[s];
            s_sat_ff[s+1]  <= s_sat_ff[s];
            s_val_ff[s+1]  <= s_val_in[s];
            s_root_ff[s+1] <= s_root_in[s];
            s_rem_ff[s+1]  <= s_rem_in[s];
         end
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s_valid_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mag_ff  <= s_sat_ff[STAGES] ? 8'hFF : s_root_ff[STAGES];
         rsp_last_ff <= s_last_ff[STAGES];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mag_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/sobel_gradient_magnitude.sv @@
// Throughput: one pixel per cycle while backpressure does not stall; the line store is a single-port-read,
// single-port-write memory and every later stage is pipelined.
// Border pixels produce no result. Backpressure stalls the whole back end.
// Reset (synchronous, active high) clears counters, window, queue and valids;
// image_width returns to 640 and image_height to 480.
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude: 3x3 Sobel edge magnitude on a raster pixel stream
// Front end classifies pixels, a short queue decouples it from the back end
// that computes floor(sqrt(gx^2 + gy^2)) saturated to 255.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH  = sgm_pkg::SGM_MAX_WIDTH,
   parameter int MAX_HEIGHT = sgm_pkg::SGM_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sgm_pkg::SGM_CSR_ADDR_W-1:0] csr_addr,
   input  logic [sgm_pkg::SGM_CSR_DATA_W-1:0] csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] pixel
   input  logic                               req_tuser,  // [0] frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [7:0] magnitude
   output logic                               rsp_tlast   // frame_end
);
   import sgm_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int FLAG_W = $bits(sgm_flags_type);
   localparam int Q_W    = COL_W + FLAG_W + SGM_PIXEL_W;

   logic                   req_accept;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   logic [Q_W-1:0]         q_push_data;
   logic [Q_W-1:0]         q_head;
   logic [COL_W-1:0]       f_col;
   sgm_flags_type          f_flags;
   logic [COL_W-1:0]       b_col;
   sgm_flags_type          b_flags;
   logic [SGM_PIXEL_W-1:0] b_pixel;

   // Accept a request whenever the queue has room
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   sgm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_accept  (req_accept),
      .frame_start (req_tuser),
      .col         (f_col),
      .flags       (f_flags)
   );

   // Pack column, flags and pixel into one queue entry
   assign q_push_data = {f_col, f_flags, req_tdata};

   sgm_queue #(
      .DATA_W (Q_W),
      .DEPTH  (SGM_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_data (q_head)
   );

   assign b_pixel = q_head[SGM_PIXEL_W-1:0];
   assign b_flags = q_head[SGM_PIXEL_W +: FLAG_W];
   assign b_col   = q_head[SGM_PIXEL_W+FLAG_W +: COL_W];

   sgm_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pixel    (b_pixel),
      .q_col      (b_col),
      .q_flags    (b_flags),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
